// ===== rtl/kms_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kms_pkg
// shared widths, constants and types of the key matrix scan and debounce block
// ----------------------------------------------------------------------------
package kms_pkg;

  localparam int ROW_W    = 5;
  localparam int COL_W    = 8;
  localparam int RELOAD_W = 8;
  localparam int COUNT_W  = 8;
  // sum of up to 32 rows of 8 bits fits in 9 bits
  localparam int SUM_W    = 9;

  localparam logic [RELOAD_W-1:0] RELOAD_AT_RESET = 8'd5;
  localparam logic [COUNT_W-1:0]  COUNT_MAX       = 8'd255;

  typedef logic [COL_W-1:0] row_bits_t;

  // control from the sequencer to the recount unit
  typedef struct packed {
    logic clear;
    logic add;
  } count_ctl_t;

  function automatic logic [3:0] ones_in(input row_bits_t v);
    logic [3:0] c;
    c = 4'd0;
    for (int n = 0; n < COL_W; n++) begin
      c = c + {3'd0, v[n]};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/kms_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kms channel interfaces
// valid/ready channels for scanned rows, results and the reload register
// ----------------------------------------------------------------------------
interface kms_row_if;
  import kms_pkg::*;
  logic                valid;
  logic                ready;
  logic [ROW_W-1:0]    row_index;
  logic [COL_W-1:0]    cols_low;
  logic                pass_end;
  modport source (output valid, row_index, cols_low, pass_end, input ready);
  modport sink   (input valid, row_index, cols_low, pass_end, output ready);
endinterface

interface kms_res_if;
  import kms_pkg::*;
  logic                valid;
  logic                ready;
  logic [COL_W-1:0]    stable_row;
  logic                settled;
  logic [COUNT_W-1:0]  key_count;
  logic                bounce_seen;
  modport source (output valid, stable_row, settled, key_count, bounce_seen,
                  input ready);
  modport sink   (input valid, stable_row, settled, key_count, bounce_seen,
                  output ready);
endinterface

interface kms_cfg_if;
  import kms_pkg::*;
  logic                valid;
  logic                ready;
  logic [RELOAD_W-1:0] debounce_reload;
  modport source (output valid, debounce_reload, input ready);
  modport sink   (input valid, debounce_reload, output ready);
endinterface
`default_nettype wire

// ===== rtl/key_matrix_scan_debounce.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// key_matrix_scan_debounce
// keyboard matrix scan with one global debounce counter
// ----------------------------------------------------------------------------
// order: an accepted row passes through ST_ROW, then ST_SHOW loads the result
//   register; when the debounce counter expires, ST_SWEEP copies and recounts the raw rows between them
// flow: a new row is taken only in ST_IDLE, once the last result is loaded; the copy and
//   recount sweep one row a cycle through the shared popcount accumulator
// reset: synchronous, clears raw and stable rows and key count, reload and
//   counter return to 5; no clearing pass
module key_matrix_scan_debounce #(
  parameter int ROW_COUNT = 18,
  parameter int COL_COUNT = 8
) (
  input wire       clk,
  input wire       rst,
  kms_row_if.sink  items,
  kms_res_if.source results,
  kms_cfg_if.sink  cfg
);
  import kms_pkg::*;

  localparam int AW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam logic [COL_W-1:0] COL_MASK =
    (COL_COUNT >= COL_W) ? {COL_W{1'b1}} : COL_W'((1 << COL_COUNT) - 1);
  localparam logic [AW-1:0] LAST_ROW = AW'(ROW_COUNT - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROW   = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_SHOW  = 2'd3;

  logic [1:0]          state;
  logic [RELOAD_W-1:0] reload;
  logic [RELOAD_W-1:0] left;
  logic [COUNT_W-1:0]  pressed_total;
  row_bits_t           raw_rows    [ROW_COUNT];
  row_bits_t           stable_rows [ROW_COUNT];

  logic [ROW_W-1:0]    row_q;
  row_bits_t           pressed_q;
  logic                pass_end_q;
  logic                bounce_q;
  logic [AW-1:0]       idx;

  logic                out_valid;
  row_bits_t           out_stable;
  logic                out_settled;
  logic [COUNT_W-1:0]  out_count;
  logic                out_bounce;

  logic                row_ok;
  logic [AW-1:0]       raw_addr;
  row_bits_t           raw_rd;
  logic                differ;
  logic [RELOAD_W-1:0] reload_eff;
  logic [RELOAD_W-1:0] left_mid;
  logic                slot_free;
  count_ctl_t          cnt_ctl;
  logic [COUNT_W-1:0]  sat_sum;

  assign items.ready = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;

  assign results.valid       = out_valid;
  assign results.stable_row  = out_stable;
  assign results.settled     = out_settled;
  assign results.key_count   = out_count;
  assign results.bounce_seen = out_bounce;

  assign row_ok     = ({1'b0, row_q} < (ROW_W + 1)'(ROW_COUNT));
  // one read port on the raw rows, shared by the compare and the sweep
  assign raw_addr   = (state == ST_SWEEP) ? idx : row_q[AW-1:0];
  assign raw_rd     = raw_rows[raw_addr];
  assign differ     = row_ok && (raw_rd != pressed_q);
  assign reload_eff = (reload == '0) ? RELOAD_W'(1) : reload;
  assign left_mid   = differ ? reload_eff : left;
  assign slot_free  = !out_valid || results.ready;

  assign cnt_ctl.clear = (state == ST_ROW);
  assign cnt_ctl.add   = (state == ST_SWEEP);

  kms_count_unit u_count (
    .clk      (clk),
    .rst      (rst),
    .ctl      (cnt_ctl),
    .row_bits (raw_rd),
    .sat_sum  (sat_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      reload <= RELOAD_AT_RESET;
    end else if (cfg.valid) begin
      reload <= cfg.debounce_reload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      left          <= RELOAD_AT_RESET;
      pressed_total <= '0;
      idx           <= '0;
      for (int r = 0; r < ROW_COUNT; r++) begin
        raw_rows[r]    <= '0;
        stable_rows[r] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (items.valid) begin
            row_q      <= items.row_index;
            pressed_q  <= ~items.cols_low & COL_MASK;
            pass_end_q <= items.pass_end;
            state      <= ST_ROW;
          end
        end
        ST_ROW: begin
          bounce_q <= differ && (left != '0);
          if (differ) begin
            raw_rows[row_q[AW-1:0]] <= pressed_q;
          end
          idx <= '0;
          if (pass_end_q && (left_mid != '0)) begin
            left <= left_mid - RELOAD_W'(1);
            // counter hits zero: copy and recount every row
            state <= (left_mid == RELOAD_W'(1)) ? ST_SWEEP : ST_SHOW;
          end else begin
            left  <= left_mid;
            state <= ST_SHOW;
          end
        end
        ST_SWEEP: begin
          stable_rows[idx] <= raw_rd;
          idx <= idx + AW'(1);
          if (idx == LAST_ROW) begin
            pressed_total <= sat_sum;
            state         <= ST_SHOW;
          end
        end
        ST_SHOW: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register, free again as soon as the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_SHOW && slot_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SHOW && slot_free) begin
      out_stable  <= row_ok ? stable_rows[row_q[AW-1:0]] : '0;
      out_settled <= (left == '0);
      out_count   <= pressed_total;
      out_bounce  <= bounce_q;
    end
  end

  a_accept_to_row: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready) |=> (state == ST_ROW))
    else $error("accepted row did not start processing");

  a_sweep_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP && idx != LAST_ROW) |=> (state == ST_SWEEP))
    else $error("sweep left before the last row");

  a_show_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHOW && slot_free) |=> (results.valid && state == ST_IDLE))
    else $error("result not presented after show");

  a_bad_row_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHOW && slot_free && !row_ok)
      |=> (results.stable_row == '0 && !results.bounce_seen))
    else $error("out of range row produced nonzero fields");

  a_sweep_settles: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (left == '0))
    else $error("sweep running while counter nonzero");

endmodule
`default_nettype wire

// ===== rtl/kms_count_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kms_count_unit
// shared popcount accumulator used to recount pressed keys one row a cycle
// ----------------------------------------------------------------------------
module kms_count_unit (
  input  wire                       clk,
  input  wire                       rst,
  input  wire kms_pkg::count_ctl_t  ctl,
  input  wire kms_pkg::row_bits_t   row_bits,
  output logic [kms_pkg::COUNT_W-1:0] sat_sum
);
  import kms_pkg::*;

  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] acc_next;

  assign acc_next = acc + {{(SUM_W-4){1'b0}}, ones_in(row_bits)};

  // saturated total including the row presented this cycle
  assign sat_sum = (acc_next > SUM_W'(COUNT_MAX)) ? COUNT_MAX : acc_next[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      acc <= '0;
    end else if (ctl.add) begin
      acc <= acc_next;
    end
  end

endmodule
`default_nettype wire

// ===== test/kms_scan_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kms_scan_checker
// watches the row, result and reload channels of the key matrix scan block,
// keeps its own copy of the raw and debounced matrices and the countdown,
// and compares each result transaction with the oldest prediction
// ----------------------------------------------------------------------------
module kms_scan_checker #(
  parameter int ROWS = 18,
  parameter int COLS = 8
) (
  input  wire  clk,
  input  wire  rst,
  kms_row_if   row_ch,
  kms_res_if   res_ch,
  kms_cfg_if   cfg_ch,
  output int   mismatches,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import kms_pkg::*;

  localparam row_bits_t COL_MASK = row_bits_t'((1 << COLS) - 1);

  typedef struct packed {
    row_bits_t          stable_row;
    logic               settled;
    logic [COUNT_W-1:0] key_count;
    logic               bounce_seen;
  } scan_result_t;

  row_bits_t           raw_img    [ROWS];
  row_bits_t           stable_img [ROWS];
  logic [RELOAD_W-1:0] countdown;
  logic [RELOAD_W-1:0] reload_val;
  logic [COUNT_W-1:0]  key_total;
  scan_result_t        pending_results[$];

  function automatic int keys_down(input row_bits_t v);
    int n;
    n = 0;
    for (int b = 0; b < COL_W; b++) n += v[b];
    return n;
  endfunction

  function automatic scan_result_t next_scan_result(input logic [ROW_W-1:0] r,
                                                    input row_bits_t cols,
                                                    input logic pe);
    scan_result_t res;
    row_bits_t    down;
    logic         in_range;
    int           total;
    res      = '0;
    down     = ~cols & COL_MASK;
    in_range = (r < ROWS);
    if (in_range && raw_img[r] != down) begin
      raw_img[r]      = down;
      res.bounce_seen = (countdown != 0);
      // a reload of zero still has to reach the stable matrix
      countdown       = (reload_val == 0) ? RELOAD_W'(1) : reload_val;
    end
    // countdown runs after the row update of the same transaction
    if (pe && countdown != 0) begin
      countdown = countdown - 1'b1;
      if (countdown == 0) begin
        total = 0;
        for (int i = 0; i < ROWS; i++) begin
          stable_img[i] = raw_img[i];
          total += keys_down(raw_img[i]);
        end
        key_total = (total > COUNT_MAX) ? COUNT_MAX : COUNT_W'(total);
      end
    end
    if (in_range) res.stable_row = stable_img[r];
    res.settled   = (countdown == 0);
    res.key_count = key_total;
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    scan_result_t got;
    scan_result_t want;
    if (rst) begin
      foreach (raw_img[i]) begin
        raw_img[i]    = '0;
        stable_img[i] = '0;
      end
      countdown  = RELOAD_AT_RESET;
      reload_val = RELOAD_AT_RESET;
      key_total  = '0;
      pending_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) reload_val = cfg_ch.debounce_reload;
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.stable_row, res_ch.settled, res_ch.key_count, res_ch.bounce_seen};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("checker: result with nothing pending: row=%h settled=%b count=%0d bounce=%b",
                     got.stable_row, got.settled, got.key_count, got.bounce_seen);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"checker: mismatch: expected row=%h settled=%b count=%0d bounce=%b,",
                        " got row=%h settled=%b count=%0d bounce=%b"},
                       want.stable_row, want.settled, want.key_count, want.bounce_seen,
                       got.stable_row, got.settled, got.key_count, got.bounce_seen);
          end
        end
      end
      if (row_ch.valid && row_ch.ready)
        pending_results.push_back(next_scan_result(row_ch.row_index, row_ch.cols_low,
                                                   row_ch.pass_end));
    end
    pending = pending_results.size();
  end

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// drives scan passes, stray rows and reload writes into the key matrix scan
// block under random idling and a long result stall; a checker predicts and
// compares every result transaction
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kms_pkg::*;

  localparam int ROWS         = 18;
  localparam int COLS         = 8;
  localparam int QUIET_LIMIT  = 5000;
  localparam int STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES = ROWS + 12;

  logic clk = 1'b0;
  logic rst;
  int   mismatches;
  int   pending;
  int   sent;
  int   send_idle;
  int   recv_idle;
  int   stall_left;
  int   quiet;
  logic hold_req;
  row_bits_t kb_cols [ROWS];

  kms_row_if row_ch ();
  kms_res_if res_ch ();
  kms_cfg_if cfg_ch ();

  key_matrix_scan_debounce #(
    .ROW_COUNT(ROWS),
    .COL_COUNT(COLS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .items  (row_ch),
    .results(res_ch),
    .cfg    (cfg_ch)
  );

  kms_scan_checker #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .row_ch    (row_ch),
    .res_ch    (res_ch),
    .cfg_ch    (cfg_ch),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        stall_left = STALL_CYCLES;
        hold_req   = 1'b0;
      end
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (row_ch.valid && row_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_row(input logic [ROW_W-1:0] r, input row_bits_t cols, input logic pe);
    logic took;
    while ($urandom_range(99) < send_idle) begin
      row_ch.valid <= 1'b0;
      @(posedge clk);
    end
    row_ch.valid     <= 1'b1;
    row_ch.row_index <= r;
    row_ch.cols_low  <= cols;
    row_ch.pass_end  <= pe;
    took = 1'b0;
    // ready is settled by the falling edge
    while (!took) begin
      @(negedge clk);
      took = row_ch.ready;
      @(posedge clk);
    end
    sent++;
  endtask

  task automatic wait_drained();
    row_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_reload(input logic [RELOAD_W-1:0] v);
    logic took;
    wait_drained();
    cfg_ch.valid           <= 1'b1;
    cfg_ch.debounce_reload <= v;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = cfg_ch.ready;
      @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // one pass over the rows in order, pass_end only on row ROWS - 1; keys toggle rarely
  task automatic scan_pass(input int flip_pct, input int last_row);
    for (int r = 0; r <= last_row; r++) begin
      if ($urandom_range(99) < flip_pct)
        kb_cols[r][$urandom_range(COLS - 1)] ^= 1'b1;
      else if ($urandom_range(199) == 0)
        kb_cols[r] = row_bits_t'($urandom);
      send_row(ROW_W'(r), kb_cols[r], r == ROWS - 1);
    end
  endtask

  task automatic run_random(input int n);
    int stop_at;
    int pick;
    stop_at = sent + n;
    while (sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        scan_pass(3, ROWS - 1);
      end else if (pick < 85) begin
        // broken pass, no end mark
        scan_pass(10, $urandom_range(ROWS - 2));
      end else begin
        repeat ($urandom_range(1, 6))
          send_row(ROW_W'($urandom_range(31)), row_bits_t'($urandom),
                   1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    rst                    = 1'b1;
    sent                   = 0;
    hold_req               = 1'b0;
    send_idle              = 27;
    recv_idle              = 78;
    row_ch.valid           = 1'b0;
    row_ch.row_index       = '0;
    row_ch.cols_low        = '1;
    row_ch.pass_end        = 1'b0;
    res_ch.ready           = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.debounce_reload = '0;
    foreach (kb_cols[i]) kb_cols[i] = '1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: reset reload value, edge rows, out-of-range rows with end marks
    send_row(5'd0, 8'h00, 1'b0);
    send_row(5'd17, 8'h7E, 1'b0);
    send_row(5'd18, 8'h00, 1'b0);
    send_row(5'd31, 8'hFF, 1'b1);
    send_row(5'd5, 8'hAA, 1'b1);
    repeat (4) send_row(5'd31, 8'hFF, 1'b1);
    // change once settled, then again while bouncing
    send_row(5'd0, 8'hFF, 1'b0);
    send_row(5'd0, 8'h00, 1'b0);
    send_row(5'd16, 8'h55, 1'b1);
    send_row(5'd17, 8'h7E, 1'b1);

    write_reload(8'd1);
    run_random(450);

    write_reload(8'd0);
    send_idle = 78;
    recv_idle = 27;
    run_random(450);

    write_reload(8'd255);
    run_random(120);

    write_reload(8'd3);
    send_idle = 0;
    recv_idle = 0;
    hold_req  = 1'b1;
    run_random(40);
    run_random(450);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
